// File: rtl/edf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDF scheduler package
// Shared types, default sizes and controller state codes.
// ----------------------------------------------------------------------------
package edf_pkg;

   localparam int unsigned DEFAULT_HEAP_DEPTH = 256;
   localparam int unsigned WORD_W             = 32;
   localparam int unsigned COUNT_OUT_W        = 9;

   typedef struct packed {
      logic [WORD_W-1:0] deadline;
      logic [WORD_W-1:0] remaining;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SU_RD,
      ST_SU_CMP,
      ST_POP_CHK,
      ST_POP_LAST,
      ST_SD_RDL,
      ST_SD_RDR,
      ST_SD_CMP,
      ST_DONE
   } state_type;

endpackage

// File: rtl/edf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDF generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module edf_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/edf_deadline_heap_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDF deadline heap scheduler core
// Earliest-deadline-first job heap kept in one RAM, one result per beat.
// ----------------------------------------------------------------------------
// Request to response beat: a rejected add goes straight to the response; an add
// sifts the new job up one level at a time (read parent, compare, write) until it
// stops or reaches the root; a tick pops each finished job and sifts the last one down.
// One item is in work at a time, so the heap RAM access sequence sets the rate;
// a new request is taken only once the last one is through; a held response adds its stall.
// Reset is synchronous: heap empty, day 1, miss flag clear, rate 1 page/day.
module edf_deadline_heap_scheduler_core #(
   parameter int unsigned HEAP_DEPTH = edf_pkg::DEFAULT_HEAP_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [31:0] req_job_deadline,
   input  logic [31:0] req_job_pages,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_deadline_missed,
   output logic        rsp_add_rejected,
   output logic [8:0]  rsp_jobs_waiting,
   output logic [8:0]  rsp_jobs_finished,
   output logic [31:0] rsp_head_deadline,
   output logic [31:0] rsp_head_remaining,
   output logic [31:0] rsp_current_day
);
   import edf_pkg::*;

   localparam int unsigned IW  = $clog2(HEAP_DEPTH);
   localparam int unsigned CW  = $clog2(HEAP_DEPTH + 1);
   localparam int unsigned CXW = IW + 2;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [WORD_W-1:0]    day_ff, day_in;
   logic                 miss_ff, miss_in;
   logic [WORD_W-1:0]    ppd_ff;
   logic [WORD_W-1:0]    budget_ff, budget_in;
   logic [CW-1:0]        fin_ff, fin_in;
   entry_type            elem_ff, elem_in;
   entry_type            left_ff, left_in;
   entry_type            head_ff;
   logic [IW-1:0]        pos_ff, pos_in;
   logic                 tick_ff, tick_in;
   logic                 rej_ff, rej_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_miss_ff;
   logic                 rsp_rej_ff;
   logic [8:0]           rsp_wait_ff;
   logic [8:0]           rsp_fin_ff;
   entry_type            rsp_head_ff;
   logic [WORD_W-1:0]    rsp_day_ff;
   logic                 rsp_load;

   logic                 wr_en, rd_en;
   logic [IW-1:0]        wr_addr, rd_addr;
   entry_type            wr_data, rd_q;

   logic [CXW-1:0]       lc, rc, cnt_x;
   logic [IW-1:0]        parent;
   logic [CW-1:0]        count_dec;

   edf_ram #(.WIDTH(ENTRY_W), .DEPTH(HEAP_DEPTH)) u_heap_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_q)
   );

   assign lc        = {1'b0, pos_ff, 1'b1};
   assign rc        = lc + CXW'(1);
   assign cnt_x     = CXW'(count_ff);
   assign parent    = (pos_ff - IW'(1)) >> 1;
   assign count_dec = count_ff - CW'(1);

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      day_in       = day_ff;
      miss_in      = miss_ff;
      budget_in    = budget_ff;
      fin_in       = fin_ff;
      elem_in      = elem_ff;
      left_in      = left_ff;
      pos_in       = pos_ff;
      tick_in      = tick_ff;
      rej_in       = rej_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = elem_ff;
      rd_en        = 1'b0;
      rd_addr      = pos_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               tick_in = req_action;
               rej_in  = 1'b0;
               fin_in  = '0;
               if (req_action) begin
                  budget_in = ppd_ff;
                  if (count_ff != '0 && head_ff.deadline <= day_ff) begin
                     miss_in = 1'b1;
                  end
                  if (day_ff != '1) begin
                     day_in = day_ff + WORD_W'(1);
                  end
                  state_in = ST_POP_CHK;
               end else if (count_ff == CW'(HEAP_DEPTH)) begin
                  rej_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  elem_in.deadline  = req_job_deadline;
                  elem_in.remaining = req_job_pages;
                  pos_in            = count_ff[IW-1:0];
                  count_in          = count_ff + CW'(1);
                  state_in          = ST_SU_RD;
               end
            end
         end
         ST_SU_RD: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = parent;
               state_in = ST_SU_CMP;
            end
         end
         ST_SU_CMP: begin
            wr_en = 1'b1;
            if (rd_q.deadline > elem_ff.deadline) begin
               wr_data  = rd_q;
               pos_in   = parent;
               state_in = ST_SU_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_POP_CHK: begin
            if (count_ff == '0) begin
               state_in = ST_DONE;
            end else if (head_ff.remaining <= budget_ff) begin
               budget_in = budget_ff - head_ff.remaining;
               fin_in    = fin_ff + CW'(1);
               count_in  = count_dec;
               if (count_dec == '0) begin
                  state_in = ST_DONE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = count_dec[IW-1:0];
                  state_in = ST_POP_LAST;
               end
            end else begin
               wr_en             = 1'b1;
               wr_addr           = '0;
               wr_data.deadline  = head_ff.deadline;
               wr_data.remaining = head_ff.remaining - budget_ff;
               state_in          = ST_DONE;
            end
         end
         ST_POP_LAST: begin
            elem_in  = rd_q;
            pos_in   = '0;
            state_in = ST_SD_RDL;
         end
         ST_SD_RDL: begin
            if (lc >= cnt_x) begin
               wr_en    = 1'b1;
               state_in = ST_POP_CHK;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = lc[IW-1:0];
               state_in = ST_SD_RDR;
            end
         end
         ST_SD_RDR: begin
            left_in = rd_q;
            if (rc < cnt_x) begin
               rd_en   = 1'b1;
               rd_addr = rc[IW-1:0];
            end
            state_in = ST_SD_CMP;
         end
         ST_SD_CMP: begin
            wr_en = 1'b1;
            // Left child wins a tie with the right child.
            if (rc < cnt_x && rd_q.deadline < left_ff.deadline
                && rd_q.deadline < elem_ff.deadline) begin
               wr_data  = rd_q;
               pos_in   = rc[IW-1:0];
               state_in = ST_SD_RDL;
            end else if (left_ff.deadline < elem_ff.deadline) begin
               wr_data  = left_ff;
               pos_in   = lc[IW-1:0];
               state_in = ST_SD_RDL;
            end else begin
               state_in = ST_POP_CHK;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         day_ff       <= WORD_W'(1);
         miss_ff      <= 1'b0;
         ppd_ff       <= WORD_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         day_ff       <= day_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            ppd_ff <= csr_wr_data;
         end
      end
   end

   // The head of the heap is mirrored in flops on every write to the root.
   always_ff @(posedge clock) begin
      budget_ff <= budget_in;
      fin_ff    <= fin_in;
      elem_ff   <= elem_in;
      left_ff   <= left_in;
      pos_ff    <= pos_in;
      tick_ff   <= tick_in;
      rej_ff    <= rej_in;
      if (wr_en && wr_addr == '0) begin
         head_ff <= wr_data;
      end
      if (rsp_load) begin
         rsp_miss_ff <= miss_ff;
         rsp_rej_ff  <= rej_ff;
         rsp_wait_ff <= COUNT_OUT_W'(count_ff);
         rsp_fin_ff  <= tick_ff ? COUNT_OUT_W'(fin_ff) : '0;
         rsp_head_ff <= (count_ff != '0) ? head_ff : '0;
         rsp_day_ff  <= day_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_deadline_missed = rsp_miss_ff;
   assign rsp_add_rejected    = rsp_rej_ff;
   assign rsp_jobs_waiting    = rsp_wait_ff;
   assign rsp_jobs_finished   = rsp_fin_ff;
   assign rsp_head_deadline   = rsp_head_ff.deadline;
   assign rsp_head_remaining  = rsp_head_ff.remaining;
   assign rsp_current_day     = rsp_day_ff;

endmodule

// File: rtl/edf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDF scheduler checker
// Port-level properties of the scheduler result stream.
// ----------------------------------------------------------------------------
module edf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_deadline_missed,
   input logic        rsp_add_rejected,
   input logic [8:0]  rsp_jobs_waiting,
   input logic [8:0]  rsp_jobs_finished,
   input logic [31:0] rsp_head_deadline,
   input logic [31:0] rsp_head_remaining
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rej_no_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_add_rejected |-> rsp_jobs_finished == 9'd0)
      else $error("rejected add reports finished jobs");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_jobs_waiting == 9'd0 |->
         rsp_head_deadline == 32'd0 && rsp_head_remaining == 32'd0)
      else $error("empty heap reports a head job");

   a_miss_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_deadline_missed |=>
         !rsp_valid || rsp_deadline_missed)
      else $error("deadline miss flag cleared");

endmodule

bind edf_deadline_heap_scheduler_core edf_checker u_edf_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_deadline_missed (rsp_deadline_missed),
   .rsp_add_rejected    (rsp_add_rejected),
   .rsp_jobs_waiting    (rsp_jobs_waiting),
   .rsp_jobs_finished   (rsp_jobs_finished),
   .rsp_head_deadline   (rsp_head_deadline),
   .rsp_head_remaining  (rsp_head_remaining)
);
